// ----- sv/cocs_pkg.sv -----
// cocs_pkg: shared types and code constants for the offset code search block
// no dependencies; imported by the top, front and back modules of the block

package cocs_pkg;

  // configuration register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_MIN_CODE   = 2'd0;
  localparam logic [1:0] REG_MAX_CODE   = 2'd1;
  localparam logic [1:0] REG_TARGET_RAW = 2'd2;
  localparam logic [1:0] REG_MARGIN_RAW = 2'd3;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_MEAS  = 2'd1,
    OP_FAIL  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [1:0] ACT_IDLE   = 2'd0;
  localparam logic [1:0] ACT_APPLY  = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_READY = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_BUS       = 3'd3;
  localparam logic [2:0] ST_TIMEOUT   = 3'd4;

  localparam logic [2:0] RSN_OK        = 3'd0;
  localparam logic [2:0] RSN_NEAR_LOW  = 3'd1;
  localparam logic [2:0] RSN_NEAR_HIGH = 3'd2;
  localparam logic [2:0] RSN_SAT_LOW   = 3'd3;
  localparam logic [2:0] RSN_SAT_HIGH  = 3'd4;
  localparam logic [2:0] RSN_BUS       = 3'd5;
  localparam logic [2:0] RSN_TIMEOUT   = 3'd6;
  localparam logic [2:0] RSN_INVALID   = 3'd7;

  // reading thresholds in raw converter units
  localparam logic signed [23:0] RAW_NEAR_HIGH = 24'sh6F0000;
  localparam logic signed [23:0] RAW_NEAR_LOW  = -24'sh700000;
  localparam logic signed [23:0] RAW_SAT_HIGH  = 24'sh7F0000;
  localparam logic signed [23:0] RAW_SAT_LOW   = -24'sh800000;

  localparam logic [24:0] ERR_ALL_ONES = '1;

  // classified item handed from front to back
  typedef struct packed {
    op_t                op;
    logic               start_ok;
    logic               fail_tmo;
    logic [2:0]         rsn;
    logic signed [23:0] raw;
    logic [24:0]        err;
  } fe_item_t;

  // one result item
  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         code;
    logic [2:0]         status;
    logic [2:0]         reason;
    logic signed [23:0] chosen_raw;
    logic               saturated;
    logic [24:0]        residual_error;
  } res_t;

endpackage

// ----- sv/capacitive_offset_code_search_top.sv -----
// capacitive_offset_code_search_top: offset code sweep with front, queue and back
// depends on cocs_pkg, cocs_front, cocs_queue, cocs_back
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+---------------------------------------
//   input    | push / full                  | in_op, in_raw_reading, in_fail_kind
//   result   | pop / empty                  | out_action .. out_residual_error
//   config   | psel penable pwrite pready   | paddr[3:0], pwdata, prdata
//
// one item per cycle sustained while results are popped: an item is classified as
// it is taken and enters the mid queue, the back pops one per cycle while the result
// queue has room and writes one result into it. an item's result passes through the
// mid queue and then the result queue before it shows on the result ports.
// rst_n is synchronous; it empties both queues, clears the sweep and loads register
// defaults. full follows the mid queue, which fills only while the result queue is full.

module capacitive_offset_code_search_top #(
  parameter int CODE_LIMIT = 31,
  parameter int MID_DEPTH  = 4,
  parameter int OUT_DEPTH  = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         in_op,
  input  logic signed [23:0] in_raw_reading,
  input  logic               in_fail_kind,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         out_action,
  output logic [7:0]         out_code,
  output logic [2:0]         out_status,
  output logic [2:0]         out_reason,
  output logic signed [23:0] out_chosen_raw,
  output logic               out_saturated,
  output logic [24:0]        out_residual_error,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import cocs_pkg::*;

  localparam int FE_W  = $bits(fe_item_t);
  localparam int RES_W = $bits(res_t);

  logic [7:0]         min_code_r;
  logic [7:0]         max_code_r;
  logic signed [23:0] target_raw_r;
  logic [23:0]        margin_raw_r;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;

  fe_item_t           fe_item;
  fe_item_t           mid_item;
  logic [FE_W-1:0]    mid_rd;
  logic               mid_empty;
  logic               back_go;
  res_t               back_res;
  res_t               out_res;
  logic [RES_W-1:0]   out_rd;
  logic               out_full;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_code_r   <= 8'd0;
      max_code_r   <= 8'd31;
      target_raw_r <= '0;
      margin_raw_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MIN_CODE:   min_code_r   <= pwdata[7:0];
        REG_MAX_CODE:   max_code_r   <= pwdata[7:0];
        REG_TARGET_RAW: target_raw_r <= pwdata[23:0];
        REG_MARGIN_RAW: margin_raw_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MIN_CODE:   prdata = {24'd0, min_code_r};
      REG_MAX_CODE:   prdata = {24'd0, max_code_r};
      REG_TARGET_RAW: prdata = {8'd0, target_raw_r};
      REG_MARGIN_RAW: prdata = {8'd0, margin_raw_r};
      default:        prdata = '0;
    endcase
  end

  cocs_front #(
    .CODE_LIMIT (CODE_LIMIT)
  ) u_front (
    .op          (op_t'(in_op)),
    .raw_reading (in_raw_reading),
    .fail_kind   (in_fail_kind),
    .min_code    (min_code_r),
    .max_code    (max_code_r),
    .target_raw  (target_raw_r),
    .item        (fe_item)
  );

  cocs_queue #(
    .WIDTH (FE_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (fe_item),
    .full    (full),
    .pop     (back_go),
    .rd_data (mid_rd),
    .empty   (mid_empty)
  );

  assign mid_item = fe_item_t'(mid_rd);
  assign back_go  = !mid_empty && !out_full;

  cocs_back #(
    .CODE_LIMIT (CODE_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (back_go),
    .item       (mid_item),
    .min_code   (min_code_r),
    .max_code   (max_code_r),
    .margin_raw (margin_raw_r),
    .res        (back_res)
  );

  cocs_queue #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (back_go),
    .wr_data (back_res),
    .full    (out_full),
    .pop     (pop),
    .rd_data (out_rd),
    .empty   (empty)
  );

  assign out_res            = res_t'(out_rd);
  assign out_action         = out_res.action;
  assign out_code           = out_res.code;
  assign out_status         = out_res.status;
  assign out_reason         = out_res.reason;
  assign out_chosen_raw     = out_res.chosen_raw;
  assign out_saturated      = out_res.saturated;
  assign out_residual_error = out_res.residual_error;

endmodule

// ----- sv/cocs_queue.sv -----
// cocs_queue: small show-ahead queue of packed items
// no package dependency; used between front and back and at the result side

module cocs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_COUNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- sv/cocs_front.sv -----
// cocs_front: classifies an incoming item against the current configuration
// depends on cocs_pkg (item types, thresholds)

module cocs_front #(
  parameter int CODE_LIMIT = 31
) (
  input  cocs_pkg::op_t           op,
  input  logic signed [23:0]      raw_reading,
  input  logic                    fail_kind,
  input  logic [7:0]              min_code,
  input  logic [7:0]              max_code,
  input  logic signed [23:0]      target_raw,
  output cocs_pkg::fe_item_t      item
);

  import cocs_pkg::*;

  localparam logic [7:0] LIMIT = 8'(CODE_LIMIT);

  logic signed [24:0] diff;
  logic [2:0]         rsn;

  // raw minus target always fits 25 signed bits
  assign diff = 25'(raw_reading) - 25'(target_raw);

  always_comb begin
    if (raw_reading >= RAW_SAT_HIGH) begin
      rsn = RSN_SAT_HIGH;
    end else if (raw_reading <= RAW_SAT_LOW) begin
      rsn = RSN_SAT_LOW;
    end else if (raw_reading >= RAW_NEAR_HIGH) begin
      rsn = RSN_NEAR_HIGH;
    end else if (raw_reading <= RAW_NEAR_LOW) begin
      rsn = RSN_NEAR_LOW;
    end else begin
      rsn = RSN_OK;
    end
  end

  always_comb begin
    item.op       = op;
    item.start_ok = (min_code <= max_code) && (max_code <= LIMIT);
    item.fail_tmo = fail_kind;
    item.rsn      = rsn;
    item.raw      = raw_reading;
    item.err      = diff[24] ? 25'(-diff) : 25'(diff);
  end

endmodule

// ----- sv/cocs_back.sv -----
// cocs_back: sweep state and result generation, one classified item per cycle while item_valid is high
// depends on cocs_pkg (item and result types, codes)

module cocs_back #(
  parameter int CODE_LIMIT = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  cocs_pkg::fe_item_t   item,
  input  logic [7:0]           min_code,
  input  logic [7:0]           max_code,
  input  logic [23:0]          margin_raw,
  output cocs_pkg::res_t       res
);

  import cocs_pkg::*;

  localparam logic [7:0] LIMIT = 8'(CODE_LIMIT);

  logic               active_r, active_nxt;
  logic [7:0]         cur_code_r, cur_code_nxt;
  logic               have_best_r, have_best_nxt;
  logic [24:0]        best_err_r, best_err_nxt;
  logic [7:0]         best_code_r, best_code_nxt;
  logic signed [23:0] best_raw_r, best_raw_nxt;
  logic [2:0]         best_rsn_r, best_rsn_nxt;
  logic [7:0]         sat_code_r, sat_code_nxt;
  logic signed [23:0] sat_raw_r, sat_raw_nxt;
  logic [2:0]         sat_rsn_r, sat_rsn_nxt;
  logic [24:0]        sat_err_r, sat_err_nxt;
  logic               is_sat;

  assign is_sat = (item.rsn == RSN_SAT_LOW) || (item.rsn == RSN_SAT_HIGH);

  always_comb begin
    active_nxt    = active_r;
    cur_code_nxt  = cur_code_r;
    have_best_nxt = have_best_r;
    best_err_nxt  = best_err_r;
    best_code_nxt = best_code_r;
    best_raw_nxt  = best_raw_r;
    best_rsn_nxt  = best_rsn_r;
    sat_code_nxt  = sat_code_r;
    sat_raw_nxt   = sat_raw_r;
    sat_rsn_nxt   = sat_rsn_r;
    sat_err_nxt   = sat_err_r;
    res           = '0;
    res.action    = ACT_IDLE;

    if (item.op == OP_START) begin
      if (!item.start_ok) begin
        active_nxt = 1'b0;
        res.status = ST_INVALID;
        res.reason = RSN_INVALID;
      end else begin
        active_nxt    = 1'b1;
        cur_code_nxt  = min_code;
        have_best_nxt = 1'b0;
        best_err_nxt  = ERR_ALL_ONES;
        best_code_nxt = '0;
        best_raw_nxt  = '0;
        best_rsn_nxt  = RSN_OK;
        sat_code_nxt  = '0;
        sat_raw_nxt   = '0;
        sat_rsn_nxt   = RSN_OK;
        sat_err_nxt   = '0;
        res.action    = ACT_APPLY;
        res.code      = min_code;
      end
    end else if (item.op == OP_NONE || !active_r) begin
      res = '0;
    end else if (item.op == OP_FAIL) begin
      active_nxt = 1'b0;
      res.code   = cur_code_r;
      res.status = item.fail_tmo ? ST_TIMEOUT : ST_BUS;
      res.reason = item.fail_tmo ? RSN_TIMEOUT : RSN_BUS;
    end else begin
      if (is_sat) begin
        sat_code_nxt = cur_code_r;
        sat_raw_nxt  = item.raw;
        sat_rsn_nxt  = item.rsn;
        sat_err_nxt  = item.err;
      end else if (!have_best_r || item.err < best_err_r) begin
        have_best_nxt = 1'b1;
        best_err_nxt  = item.err;
        best_code_nxt = cur_code_r;
        best_raw_nxt  = item.raw;
        best_rsn_nxt  = item.rsn;
      end

      if (!is_sat && item.err <= {1'b0, margin_raw}) begin
        // close enough, stop early on this code
        active_nxt         = 1'b0;
        res.action         = ACT_FINISH;
        res.code           = cur_code_r;
        res.reason         = item.rsn;
        res.chosen_raw     = item.raw;
        res.residual_error = item.err;
      end else if (cur_code_r >= max_code || cur_code_r >= LIMIT) begin
        active_nxt = 1'b0;
        res.action = ACT_FINISH;
        if (have_best_nxt) begin
          res.code           = best_code_nxt;
          res.reason         = best_rsn_nxt;
          res.chosen_raw     = best_raw_nxt;
          res.residual_error = best_err_nxt;
        end else begin
          // every reading saturated
          res.code           = sat_code_nxt;
          res.status         = ST_NOT_READY;
          res.reason         = sat_rsn_nxt;
          res.chosen_raw     = sat_raw_nxt;
          res.saturated      = 1'b1;
          res.residual_error = sat_err_nxt;
        end
      end else begin
        cur_code_nxt = cur_code_r + 8'd1;
        res.action   = ACT_APPLY;
        res.code     = cur_code_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cur_code_r  <= '0;
      have_best_r <= 1'b0;
      best_err_r  <= ERR_ALL_ONES;
      best_code_r <= '0;
      best_raw_r  <= '0;
      best_rsn_r  <= RSN_OK;
      sat_code_r  <= '0;
      sat_raw_r   <= '0;
      sat_rsn_r   <= RSN_OK;
      sat_err_r   <= '0;
    end else if (item_valid) begin
      active_r    <= active_nxt;
      cur_code_r  <= cur_code_nxt;
      have_best_r <= have_best_nxt;
      best_err_r  <= best_err_nxt;
      best_code_r <= best_code_nxt;
      best_raw_r  <= best_raw_nxt;
      best_rsn_r  <= best_rsn_nxt;
      sat_code_r  <= sat_code_nxt;
      sat_raw_r   <= sat_raw_nxt;
      sat_rsn_r   <= sat_rsn_nxt;
      sat_err_r   <= sat_err_nxt;
    end
  end

endmodule
